// ===== hw/rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic reducer
// Holds the payload structs, action codes and status codes.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  status;
    } out_item_t;

endpackage

// ===== hw/rtl/rar_mul.sv =====
// ----------------------------------------------------------------------------
// rar_mul: shared registered magnitude multiplier
// One WIDTH by WIDTH unsigned product per cycle, result registered.
// ----------------------------------------------------------------------------
module rar_mul (
    input  logic                   clk,
    input  logic [rar_pkg::WIDTH-1:0] op_a,
    input  logic [rar_pkg::WIDTH-1:0] op_b,
    output logic [rar_pkg::DW-1:0]    prod
);
    import rar_pkg::*;

    logic [DW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= DW'(op_a) * DW'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/rational_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce: exact rational add, subtract, multiply, divide
// Computes a op b on signed fractions and returns the reduced fraction.
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) carries action and two fractions.
//   out channel (out_valid/out_stall/out_data) returns one reduced fraction
//   with a status code for each input transfer.
//   in_stall is high from the input transfer until the result has been
//   loaded into the output register; one item is computed at a time.
//   sequence: the products are formed in S_MUL0, S_MUL1, S_MUL2 and S_COMB,
//   then a binary gcd shifts or subtracts once per cycle on double-width
//   magnitudes, then two restoring divisions by the gcd run at one quotient bit
//   per cycle, then S_OUT normalizes and clamps. a zero numerator or
//   denominator skips the gcd loop and the divisions.
//   reset clears the sequencer and output valid; no memory is cleared.
//   when out_stall is high the result is held stable in the output register
//   and a finished next result waits, with in_stall high, until it is free.
// ----------------------------------------------------------------------------
module rational_arith_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rar_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rar_pkg::out_item_t out_data
);
    import rar_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MUL0  = 11'b00000000010,
        S_MUL1  = 11'b00000000100,
        S_MUL2  = 11'b00000001000,
        S_COMB  = 11'b00000010000,
        S_GTWO  = 11'b00000100000,
        S_GODD  = 11'b00001000000,
        S_GLOOP = 11'b00010000000,
        S_DIVN  = 11'b00100000000,
        S_DIVD  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

    state_t state_reg, state_next;

    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic             an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic             add_reg;
    logic [DW-1:0]    p_reg, d_reg;
    logic [DW-1:0]    u_reg, v_reg;
    logic [CW-1:0]    sh_reg, cnt_reg;
    logic [DW-1:0]    nm_reg, dm_reg;
    logic             n_s_reg;
    logic [DW-1:0]    rem_reg, quo_reg, g_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;
    out_item_t        out_next;

    logic [WIDTH-1:0] mul_a, mul_b;
    logic [DW-1:0]    prod;

    rar_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    function automatic logic [WIDTH:0] split(input logic [31:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        if (v[WIDTH-1])
            return {1'b1, WIDTH'(~v + WIDTH'(1))};
        return {1'b0, v};
    endfunction

    always_comb
    begin
        unique case (state_reg)
            S_MUL0:  begin mul_a = ad_reg; mul_b = bd_reg; end
            S_MUL1:  begin mul_a = an_reg; mul_b = add_reg ? bd_reg : bn_reg; end
            default: begin mul_a = bn_reg; mul_b = ad_reg; end
        endcase
    end

    // restoring division step on the shared remainder
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, g_reg};

    logic [DW-1:0] gdiff;
    assign gdiff = v_reg - u_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MUL0;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_COMB;
            S_COMB:  state_next = S_GTWO;
            S_GTWO:
            begin
                // zero numerator or denominator needs no reduction
                if (nm_reg == '0 || dm_reg == '0)
                    state_next = S_OUT;
                else if (u_reg[0] | v_reg[0])
                    state_next = S_GODD;
            end
            S_GODD:  if (u_reg[0]) state_next = S_GLOOP;
            S_GLOOP: if (v_reg == '0) state_next = S_DIVN;
            S_DIVN:  if (cnt_reg == CW'(DW - 1)) state_next = S_DIVD;
            S_DIVD:  if (cnt_reg == CW'(DW - 1)) state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    logic [WIDTH:0] s_an, s_ad, s_bn, s_bd;
    assign s_an = split(in_data.a_num);
    assign s_ad = split(in_data.a_den);
    assign s_bn = split(in_data.b_num);
    assign s_bd = split(in_data.b_den);

    logic [DW-1:0] nmax, n_c, d_c;
    logic          ovf;
    always_comb
    begin
        nmax = n_s_reg ? LIM : LIM - DW'(1);
        n_c  = nm_reg;
        d_c  = dm_reg;
        ovf  = 1'b0;
        if (nm_reg > nmax)
        begin
            n_c = nmax;
            ovf = 1'b1;
        end
        if (dm_reg > LIM - DW'(1))
        begin
            d_c = LIM - DW'(1);
            ovf = 1'b1;
        end
        if (dm_reg == '0)
        begin
            out_next.res_num = '0;
            out_next.res_den = '0;
            out_next.status  = ST_ZERO;
        end
        else if (nm_reg == '0)
        begin
            out_next.res_num = '0;
            out_next.res_den = 31'(1);
            out_next.status  = ST_OK;
        end
        else
        begin
            out_next.res_num = 32'($signed(n_s_reg ? WIDTH'(~n_c[WIDTH-1:0] + WIDTH'(1))
                                                   : n_c[WIDTH-1:0]));
            out_next.res_den = 31'(d_c[WIDTH-1:0]);
            out_next.status  = ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                an_reg   <= s_an[WIDTH-1:0];
                an_s_reg <= s_an[WIDTH];
                ad_reg   <= s_ad[WIDTH-1:0];
                ad_s_reg <= s_ad[WIDTH];
                add_reg  <= (in_data.action == ACT_ADD) || (in_data.action == ACT_SUB);
                if (in_data.action == ACT_DIV)
                begin
                    bn_reg   <= s_bd[WIDTH-1:0];
                    bn_s_reg <= s_bd[WIDTH];
                    bd_reg   <= s_bn[WIDTH-1:0];
                    bd_s_reg <= s_bn[WIDTH];
                end
                else
                begin
                    bn_reg   <= s_bn[WIDTH-1:0];
                    bn_s_reg <= s_bn[WIDTH] ^ (in_data.action == ACT_SUB);
                    bd_reg   <= s_bd[WIDTH-1:0];
                    bd_s_reg <= s_bd[WIDTH];
                end
            end
            S_MUL1:  d_reg <= prod;
            S_MUL2:  p_reg <= prod;
            S_COMB:
            begin
                // numerator combine with q taken straight from the multiplier
                if (!add_reg)
                begin
                    nm_reg  <= p_reg;
                    n_s_reg <= an_s_reg ^ bn_s_reg ^ ad_s_reg ^ bd_s_reg;
                end
                else if ((an_s_reg ^ bd_s_reg) == (bn_s_reg ^ ad_s_reg))
                begin
                    nm_reg  <= p_reg + prod;
                    n_s_reg <= an_s_reg ^ bd_s_reg ^ ad_s_reg ^ bd_s_reg;
                end
                else if (p_reg >= prod)
                begin
                    nm_reg  <= p_reg - prod;
                    n_s_reg <= an_s_reg ^ ad_s_reg;
                end
                else
                begin
                    nm_reg  <= prod - p_reg;
                    n_s_reg <= bn_s_reg ^ ad_s_reg ^ ad_s_reg ^ bd_s_reg;
                end
                dm_reg <= d_reg;
                sh_reg <= '0;
                // gcd runs on u/v; u is loaded in the first S_GTWO cycle
                u_reg  <= '0;
                v_reg  <= d_reg;
            end
            S_GTWO:
            begin
                if (u_reg == '0)
                    u_reg <= nm_reg;
                else if (!(u_reg[0] | v_reg[0]))
                begin
                    u_reg  <= u_reg >> 1;
                    v_reg  <= v_reg >> 1;
                    sh_reg <= sh_reg + CW'(1);
                end
            end
            S_GODD:
                if (!u_reg[0]) u_reg <= u_reg >> 1;
            S_GLOOP:
            begin
                if (v_reg != '0)
                begin
                    if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= v_reg;
                        v_reg <= u_reg - v_reg;
                    end
                    else
                        v_reg <= gdiff;
                end
                else
                begin
                    g_reg   <= u_reg << sh_reg;
                    rem_reg <= '0;
                    quo_reg <= nm_reg;
                    cnt_reg <= '0;
                end
            end
            S_DIVN:
            begin
                if (cnt_reg == CW'(DW - 1))
                begin
                    nm_reg  <= {quo_reg[DW-2:0], !rem_sub[DW]};
                    rem_reg <= '0;
                    quo_reg <= dm_reg;
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    rem_reg <= rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], !rem_sub[DW]};
                end
            end
            S_DIVD:
            begin
                if (cnt_reg == CW'(DW - 1))
                    dm_reg <= {quo_reg[DW-2:0], !rem_sub[DW]};
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    rem_reg <= rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], !rem_sub[DW]};
                end
            end
            S_OUT:
                if (!out_valid_reg || !out_stall)
                    out_reg <= out_next;
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== dv/rational_arith_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_tb: self-checking bench for the rational reducer
// Drives random and corner-case fraction pairs with every action, predicts
// the reduced, sign-normalized result and checks each output transfer.
// ----------------------------------------------------------------------------
module rational_arith_reduce_tb;
    import rar_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int PAUSE_AT       = 300;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    in_item_t  pending_q[$];
    out_item_t fraction_q[$];
    int        errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        idle_cycles = 0;
    int        send_gap;
    int        recv_gap;
    int        long_hold;
    bit        hold_req;
    int        act_seen[4] = '{0, 0, 0, 0};
    int        zero_seen = 0;
    int        ovf_seen = 0;

    rational_arith_reduce dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // split a signed WIDTH-bit field into sign and magnitude
    function automatic void to_sign_mag(input logic [31:0] raw, output bit neg,
                                        output logic [63:0] mag);
        logic [WIDTH-1:0] v;
        v   = raw[WIDTH-1:0];
        neg = v[WIDTH-1];
        mag = neg ? 64'(-$signed({1'b1, v})) : 64'(v);
        if (neg)
            mag = (64'd1 << WIDTH) - 64'(v);
    endfunction

    function automatic logic [63:0] binary_gcd(input logic [63:0] u, input logic [63:0] v);
        logic [63:0] t;
        int          sh;
        sh = 0;
        while (((u | v) & 64'd1) == 0)
        begin
            u = u >> 1;
            v = v >> 1;
            sh++;
        end
        while ((u & 64'd1) == 0)
            u = u >> 1;
        while (v != 0)
        begin
            while ((v & 64'd1) == 0)
                v = v >> 1;
            if (u > v)
            begin
                t = u;
                u = v;
                v = t;
            end
            v = v - u;
        end
        return u << sh;
    endfunction

    function automatic out_item_t reduce_fraction(input in_item_t it);
        out_item_t   r;
        bit          an_s, ad_s, bn_s, bd_s, n_s, d_s, p_s, q_s, ts;
        logic [63:0] an, ad, bn, bd, nm, dm, p, q, tm, g, lim, rn;
        logic [1:0]  st;
        action_t     act;
        act = action_t'(it.action);
        to_sign_mag(it.a_num, an_s, an);
        to_sign_mag(it.a_den, ad_s, ad);
        to_sign_mag(it.b_num, bn_s, bn);
        to_sign_mag(it.b_den, bd_s, bd);
        lim = 64'd1 << (WIDTH - 1);
        st  = ST_OK;
        if (act == ACT_SUB)
            bn_s = !bn_s;
        if (act == ACT_DIV)
        begin
            ts = bn_s;
            tm = bn;
            bn_s = bd_s;
            bn = bd;
            bd_s = ts;
            bd = tm;
        end
        d_s = ad_s != bd_s;
        dm  = ad * bd;
        if (act == ACT_ADD || act == ACT_SUB)
        begin
            p_s = an_s != bd_s;
            q_s = bn_s != ad_s;
            p = an * bd;
            q = bn * ad;
            if (p_s == q_s)
            begin
                n_s = p_s;
                nm = p + q;
            end
            else if (p >= q)
            begin
                n_s = p_s;
                nm = p - q;
            end
            else
            begin
                n_s = q_s;
                nm = q - p;
            end
        end
        else
        begin
            n_s = an_s != bn_s;
            nm  = an * bn;
        end
        if (dm == 0)
        begin
            r.res_num = '0;
            r.res_den = '0;
            r.status  = ST_ZERO;
            return r;
        end
        if (nm == 0)
        begin
            r.res_num = '0;
            r.res_den = 31'd1;
            r.status  = ST_OK;
            return r;
        end
        g   = binary_gcd(nm, dm);
        nm  = nm / g;
        dm  = dm / g;
        n_s = n_s != d_s;
        if (n_s && nm > lim)
        begin
            nm = lim;
            st = ST_OVF;
        end
        else if (!n_s && nm > lim - 1)
        begin
            nm = lim - 1;
            st = ST_OVF;
        end
        if (dm > lim - 1)
        begin
            dm = lim - 1;
            st = ST_OVF;
        end
        rn = n_s ? 64'd0 - nm : nm;
        r.res_num = rn[31:0];
        r.res_den = dm[30:0];
        r.status  = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'($signed($urandom_range(0, 40)) - 20);
            5: return 32'($urandom_range(1, 1000)) << $urandom_range(0, 20);
            6: return -(32'($urandom_range(1, 1000)) << $urandom_range(0, 20));
            7: return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input action_t act, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd);
        in_item_t it;
        it.action = act;
        it.a_num  = an;
        it.a_den  = ad;
        it.b_num  = bn;
        it.b_den  = bd;
        pending_q.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch on %s: got %h expected %h (result %0d)", what, got, want,
                 n_checked);
    endtask

    // stimulus
    initial
    begin
        action_t a;
        int      i;
        for (i = 0; i < 4; i++)
        begin
            a = action_t'(i);
            add_item(a, 32'd1, 32'd2, 32'd1, 32'd3);
            add_item(a, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
            add_item(a, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        end
        add_item(ACT_ADD, 32'd5, 32'd0, 32'd1, 32'd2);
        add_item(ACT_MUL, 32'd5, 32'd7, 32'd1, 32'd0);
        add_item(ACT_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
        add_item(ACT_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
        add_item(ACT_MUL, 32'd0, 32'hffff_fffd, 32'd9, 32'd2);
        add_item(ACT_ADD, 32'hffff_ffff, 32'd2, 32'd1, 32'hffff_fffe);
        add_item(ACT_DIV, 32'hffff_fffa, 32'd4, 32'd3, 32'hffff_fff8);
        add_item(ACT_MUL, 32'h7fff_ffff, 32'd1, 32'd2, 32'd1);
        add_item(ACT_DIV, 32'd1, 32'h7fff_ffff, 32'd2, 32'd1);
        add_item(ACT_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        for (i = 0; i < 550; i++)
            add_item(action_t'($urandom_range(0, 3)), pick_value(), pick_value(),
                     pick_value(), pick_value());
    end

    // driver; after PAUSE_AT transfers it waits until nothing is outstanding
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            fraction_q.push_back(reduce_fraction(in_data));
            act_seen[in_data.action]++;
            n_sent++;
            void'(pending_q.pop_front());
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                              : $urandom_range(0, 3) * $urandom_range(0, 1);
            send_gap <= gap;
            if (gap == 0 && pending_q.size() > 0 && n_sent != PAUSE_AT)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_q[0];
            end
            else
                in_valid <= 1'b0;
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_q.size() > 0 && !(n_sent == PAUSE_AT && fraction_q.size() > 0))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_q[0];
            end
        end
    end

    // receiver stall, with one long hold while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            recv_gap  <= 0;
            long_hold <= 0;
            hold_req  <= 1'b1;
        end
        else if (hold_req && n_sent >= 40)
        begin
            hold_req  <= 1'b0;
            long_hold <= 3000;
            out_stall <= 1'b1;
        end
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            out_stall <= (long_hold > 1);
        end
        else if (recv_gap > 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_stall <= (recv_gap > 1);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            recv_gap  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                     : $urandom_range(1, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fraction_q.size() == 0)
                report_mismatch("unexpected output transfer", out_data.res_num, 32'd0);
            else
            begin
                want = fraction_q.pop_front();
                if (out_data.res_num !== want.res_num)
                    report_mismatch("res_num", out_data.res_num, want.res_num);
                if (out_data.res_den !== want.res_den)
                    report_mismatch("res_den", 32'(out_data.res_den), 32'(want.res_den));
                if (out_data.status !== want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (want.status == ST_ZERO)
                    zero_seen++;
                if (want.status == ST_OVF)
                    ovf_seen++;
            end
            n_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_q.size() > 0 || in_valid)
            @(posedge clk);
        while (fraction_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d results: add %0d sub %0d mul %0d div %0d", n_checked,
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
        $display("zero-denominator results %0d, saturated results %0d, mismatches %0d",
                 zero_seen, ovf_seen, errors);
        if (errors == 0 && fraction_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
